>>> design/assert_macros.svh
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_NEVER(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, prop, msg)
`endif
`endif

>>> design/ifrs_pkg.sv
// ----------------------------------------------------------------------------
// ifrs_pkg
// Shared types and constants for the inverse-fitness roulette select core.
// ----------------------------------------------------------------------------
package ifrs_pkg;
    localparam int MAX_ENTRIES_DEF = 16;
    localparam logic [7:0] WHEEL_SLOTS_RESET = 8'd100;

    localparam logic [1:0] OP_RESTART = 2'd0;
    localparam logic [1:0] OP_APPEND  = 2'd1;
    localparam logic [1:0] OP_DRAW    = 2'd2;
    localparam logic [1:0] OP_UNUSED  = 2'd3;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_DEGEN  = 2'd2;
    localparam logic [1:0] ST_EMPTY  = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE, S_RD1, S_DIV1, S_ACC1, S_CHK, S_MOD, S_RD2, S_DIV2, S_ACC2, S_OUT
    } t_state;
endpackage

>>> design/inverse_fitness_roulette_select_core.sv
// ----------------------------------------------------------------------------
// inverse_fitness_roulette_select_core
// Fitness store with inverse-fitness roulette draw, one shared serial divider.
// ----------------------------------------------------------------------------
// channel | valid   | stall   | payload
// in      | i_valid | o_stall | i_opcode, i_fitness_value, i_random_word
// out     | o_valid | i_stall | o_chosen_index, o_slot_total, o_status
// cfg     | i_cfg_we| -       | i_cfg_data
// Restart, append and rejected draws go straight from acceptance to S_OUT.
// A draw walks the stored entries in two passes, each entry costing a read, a
// bit-serial division and an accumulate step; between the passes a check and a
// modulo run, and an output step ends the draw; pass two stops at the chosen entry.
// Reset is synchronous; the store itself is not cleared.
// One item is in work at a time; a held result stalls the next item.
`include "assert_macros.svh"
module inverse_fitness_roulette_select_core #(
    parameter int MAX_ENTRIES = ifrs_pkg::MAX_ENTRIES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_opcode,
    input  logic [31:0] i_fitness_value,
    input  logic [30:0] i_random_word,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [3:0]  o_chosen_index,
    output logic [7:0]  o_slot_total,
    output logic [1:0]  o_status,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_data
);
    import ifrs_pkg::*;

    localparam int AW = $clog2(MAX_ENTRIES);
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int SW = 32 + AW;
    localparam int NW = SW + 8;
    localparam int DW = SW + CW;
    localparam int QCW = $clog2(NW + 1);

    logic [31:0] r_mem [MAX_ENTRIES];
    logic [31:0] r_rd;
    logic [AW-1:0] r_raddr;
    logic        r_we;
    logic [AW-1:0] r_waddr;
    logic [31:0] r_wdata;

    t_state r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [SW-1:0] r_sum, n_sum;
    logic [7:0]  r_slots;
    logic [CW-1:0] r_i, n_i;
    logic [DW-1:0] r_den, n_den;
    logic [NW-1:0] r_num, n_num;
    logic [DW:0]   r_rem, n_rem;
    logic [QCW-1:0] r_bit, n_bit;
    logic [8:0]  r_base, n_base;
    logic [30:0] r_rw, n_rw;
    logic [8:0]  r_slot, n_slot;
    logic [3:0]  r_idx, n_idx;
    logic        r_ov, n_ov;
    logic [3:0]  r_oidx, n_oidx;
    logic [7:0]  r_otot, n_otot;
    logic [1:0]  r_ost, n_ost;
    logic        n_we;
    logic [AW-1:0] n_waddr;
    logic [31:0] n_wdata;
    logic        acc;
    logic [DW:0] rem_sh, rem_sub;
    logic [8:0]  share;
    logic [9:0]  mrem_sh;

    assign o_stall = (r_state != S_IDLE) || r_ov;
    assign acc = i_valid && !o_stall;
    assign o_valid = r_ov;
    assign o_chosen_index = r_oidx;
    assign o_slot_total = r_otot;
    assign o_status = r_ost;

    always_ff @(posedge i_clk) begin
        if (r_we) begin
            r_mem[r_waddr] <= r_wdata;
        end
        r_rd <= r_mem[r_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt <= '0;
            r_sum <= '0;
            r_slots <= WHEEL_SLOTS_RESET;
            r_ov <= 1'b0;
            r_we <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt <= n_cnt;
            r_sum <= n_sum;
            r_ov <= n_ov;
            r_we <= n_we;
            if (i_cfg_we) begin
                r_slots <= i_cfg_data;
            end
        end
        r_waddr <= n_waddr;
        r_wdata <= n_wdata;
        r_raddr <= n_i[AW-1:0];
        r_i <= n_i; r_den <= n_den; r_num <= n_num; r_rem <= n_rem; r_bit <= n_bit;
        r_base <= n_base; r_rw <= n_rw; r_slot <= n_slot; r_idx <= n_idx;
        r_oidx <= n_oidx; r_otot <= n_otot; r_ost <= n_ost;
    end

    always_comb begin
        n_state = r_state; n_cnt = r_cnt; n_sum = r_sum; n_i = r_i; n_den = r_den;
        n_num = r_num; n_rem = r_rem; n_bit = r_bit; n_base = r_base; n_rw = r_rw;
        n_slot = r_slot; n_idx = r_idx; n_ov = r_ov; n_oidx = r_oidx;
        n_otot = r_otot; n_ost = r_ost; n_we = 1'b0; n_waddr = r_waddr;
        n_wdata = r_wdata;
        rem_sh = {r_rem[DW-1:0], r_num[NW-1]};
        rem_sub = rem_sh - {1'b0, r_den};
        share = r_num[8:0];
        mrem_sh = {r_slot, r_rw[30]};
        if (r_ov && !i_stall) begin
            n_ov = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (acc) begin
                    n_oidx = '0; n_otot = '0; n_ost = ST_OK;
                    n_state = S_OUT;
                    case (i_opcode)
                        OP_RESTART: begin
                            n_we = 1'b1; n_waddr = '0; n_wdata = i_fitness_value;
                            n_cnt = CW'(1); n_sum = SW'(i_fitness_value);
                        end
                        OP_APPEND: begin
                            if (r_cnt >= CW'(MAX_ENTRIES)) begin
                                n_ost = ST_FULL;
                            end else begin
                                n_we = 1'b1; n_waddr = r_cnt[AW-1:0];
                                n_wdata = i_fitness_value;
                                n_cnt = r_cnt + CW'(1);
                                n_sum = r_sum + SW'(i_fitness_value);
                            end
                        end
                        OP_DRAW: begin
                            if (r_cnt < CW'(2) || r_sum == '0) begin
                                n_ost = ST_DEGEN;
                            end else begin
                                n_den = DW'(r_sum) * DW'(r_cnt - CW'(1));
                                n_i = '0; n_base = '0; n_rw = i_random_word;
                                n_state = S_RD1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_RD1, S_RD2: begin
                n_state = (r_state == S_RD1) ? S_DIV1 : S_DIV2;
                n_bit = '0; n_rem = '0; n_num = '0;
            end
            S_DIV1, S_DIV2: begin
                if (r_bit == '0 && r_num == '0 && r_rem == '0) begin
                    n_num = NW'(r_sum - SW'(r_rd)) * NW'(r_slots);
                    n_bit = QCW'(1);
                end else if (r_bit <= QCW'(NW)) begin
                    if (!rem_sub[DW]) begin
                        n_rem = rem_sub;
                    end else begin
                        n_rem = rem_sh;
                    end
                    n_num = {r_num[NW-2:0], !rem_sub[DW]};
                    n_bit = r_bit + QCW'(1);
                    if (r_bit == QCW'(NW)) begin
                        n_state = (r_state == S_DIV1) ? S_ACC1 : S_ACC2;
                    end
                end
            end
            S_ACC1: begin
                n_base = r_base + share;
                n_i = r_i + CW'(1);
                n_state = (r_i + CW'(1) >= r_cnt) ? S_CHK : S_RD1;
            end
            S_CHK: begin
                if (r_base == '0) begin
                    n_ost = ST_EMPTY; n_state = S_OUT;
                end else begin
                    n_slot = '0; n_bit = '0; n_state = S_MOD;
                end
            end
            S_MOD: begin
                if (mrem_sh >= {1'b0, r_base}) begin
                    n_slot = 9'(mrem_sh - {1'b0, r_base});
                end else begin
                    n_slot = mrem_sh[8:0];
                end
                n_rw = {r_rw[29:0], 1'b0};
                n_bit = r_bit + QCW'(1);
                if (r_bit == QCW'(30)) begin
                    n_i = '0; n_idx = '0; n_state = S_RD2;
                end
            end
            S_ACC2: begin
                if (r_slot < share) begin
                    n_idx = 4'(r_i);
                    n_state = S_OUT;
                end else begin
                    n_slot = r_slot - share;
                    n_i = r_i + CW'(1);
                    n_state = (r_i + CW'(1) >= r_cnt) ? S_OUT : S_RD2;
                end
                n_otot = r_base[7:0];
            end
            S_OUT: begin
                if (r_ost == ST_OK && r_otot != '0) begin
                    n_oidx = n_idx;
                end
                n_ov = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    `ASSERT_NEVER(a_out_busy, i_clk, i_rst_n, o_valid && (r_state != S_IDLE), "result during work")
    `ASSERT_NEVER(a_cnt_range, i_clk, i_rst_n, r_cnt > CW'(MAX_ENTRIES), "entry count overflow")
    `ASSERT_CLK(a_hold, i_clk, i_rst_n, (o_valid && i_stall) |=> o_valid, "result dropped")
endmodule
